// ----- src/tccw_pkg.sv -----
// Shared types, constants and helpers of the text console cursor writer.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

    localparam int COLUMNS_DEF         = 16;
    localparam int ROWS_DEF            = 8;
    localparam int FIRST_PRINTABLE_DEF = 32;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_HEX  = 2'd1;
    localparam logic [1:0] KIND_DEC  = 2'd2;
    localparam logic [1:0] KIND_MOVE = 2'd3;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_ZERO    = 8'd48;
    localparam logic [7:0] CODE_TOP     = 8'd127;

    localparam logic [3:0] HEX_LAST_IDX = 4'd7;
    localparam logic [3:0] DEC_LAST_IDX = 4'd9;
    localparam int         DIGIT_DEPTH  = 10;

    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;

    typedef struct packed {
        logic accept;
        logic dec_mul;
        logic step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last_digit;
        logic idx_zero;
    } dp_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        begin
            case (d)
                4'h0: c = 8'h30;
                4'h1: c = 8'h31;
                4'h2: c = 8'h32;
                4'h3: c = 8'h33;
                4'h4: c = 8'h34;
                4'h5: c = 8'h35;
                4'h6: c = 8'h36;
                4'h7: c = 8'h37;
                4'h8: c = 8'h38;
                4'h9: c = 8'h39;
                4'hA: c = 8'h41;
                4'hB: c = 8'h42;
                4'hC: c = 8'h43;
                4'hD: c = 8'h44;
                4'hE: c = 8'h45;
                default: c = 8'h46;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/tccw_in_if.sv -----
// Input channel interface: command words with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface tccw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [31:0] number;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;

    modport source (output valid, output kind, output char_code, output number,
                     output pos_x, output pos_y, input ready);
    modport sink (input valid, input kind, input char_code, input number,
                   input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

// ----- src/tccw_out_if.sv -----
// Output channel interface: glyph words with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface tccw_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] glyph_index;
    logic [3:0] cell_column;
    logic [2:0] cell_row;
    logic       last;

    modport source (output valid, output glyph_index, output cell_column,
                     output cell_row, output last, input ready);
    modport sink (input valid, input glyph_index, input cell_column,
                   input cell_row, input last, output ready);
endinterface

`default_nettype wire

// ----- src/tccw_datapath.sv -----
// Datapath: cursor, digit extraction, digit store and output word register.
`timescale 1ns / 1ps
`default_nettype none

module tccw_datapath #(
    parameter int COLUMNS         = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS            = tccw_pkg::ROWS_DEF,
    parameter int FIRST_PRINTABLE = tccw_pkg::FIRST_PRINTABLE_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tccw_pkg::dp_cmd_t    cmd,
    output tccw_pkg::dp_status_t      status,
    input  wire logic [1:0]           kind,
    input  wire logic [7:0]           char_code,
    input  wire logic [31:0]          number,
    input  wire logic [7:0]           pos_x,
    input  wire logic [7:0]           pos_y,
    output logic [6:0]                glyph_index,
    output logic [3:0]                cell_column,
    output logic [2:0]                cell_row,
    output logic                      last
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam logic [CW-1:0] COL_MAX  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_MAX  = RW'(ROWS - 1);
    localparam logic [8:0]    COL_LIM  = 9'(COLUMNS);
    localparam logic [8:0]    ROW_LIM  = 9'(ROWS);
    localparam logic [7:0]    FP_CODE  = 8'(FIRST_PRINTABLE);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          skip_reg, skip_next;
    logic [3:0]    idx_reg, idx_next;

    logic [31:0]   num_reg;
    logic [63:0]   prod_reg;
    logic [1:0]    kind_reg;
    logic [7:0]    code_reg;
    logic [3:0]    digit_reg [tccw_pkg::DIGIT_DEPTH];
    logic [6:0]    glyph_reg;
    logic [3:0]    cellc_reg;
    logic [2:0]    cellr_reg;
    logic          last_reg;

    logic [RW-1:0] row_inc;
    logic          pos_ok;
    logic [31:0]   quot;
    logic [31:0]   mul_in;
    logic [3:0]    q10_low;
    logic [3:0]    dec_digit;
    logic [3:0]    new_digit;
    logic          last_digit;
    logic [3:0]    rd_digit;
    logic [7:0]    code;
    logic [7:0]    glyph_w;
    logic [6:0]    glyph;
    logic [7:0]    col_w;
    logic [7:0]    row_w;

    assign row_inc = (row_reg == ROW_MAX) ? '0 : row_reg + 1'b1;
    assign pos_ok  = ({1'b0, pos_x} < COL_LIM) && ({1'b0, pos_y} < ROW_LIM);

    assign quot      = 32'(prod_reg[63:tccw_pkg::DEC_SHIFT]);
    assign mul_in    = cmd.dec_mul ? num_reg : quot;
    assign q10_low   = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign dec_digit = num_reg[3:0] - q10_low;
    assign new_digit = (kind_reg == tccw_pkg::KIND_HEX) ? num_reg[3:0] : dec_digit;

    always_comb
    begin
        if (kind_reg == tccw_pkg::KIND_HEX)
        begin
            last_digit = (num_reg[31:4] == 28'd0) || (idx_reg == tccw_pkg::HEX_LAST_IDX);
        end
        else
        begin
            last_digit = (quot == 32'd0) || (idx_reg == tccw_pkg::DEC_LAST_IDX);
        end
    end

    assign status.last_digit = last_digit;
    assign status.idx_zero   = (idx_reg == 4'd0);

    assign rd_digit = digit_reg[idx_reg];

    always_comb
    begin
        case (kind_reg)
            tccw_pkg::KIND_CHAR: code = code_reg;
            tccw_pkg::KIND_HEX:  code = tccw_pkg::hex_char(rd_digit);
            default:             code = tccw_pkg::CODE_ZERO + {4'b0000, rd_digit};
        endcase
    end

    assign glyph_w = code - FP_CODE;
    assign glyph   = (code >= FP_CODE && code <= tccw_pkg::CODE_TOP) ? glyph_w[6:0] : 7'd0;
    assign col_w   = 8'(col_reg);
    assign row_w   = 8'(row_reg);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        skip_next = skip_reg;
        idx_next  = idx_reg;
        if (cmd.accept)
        begin
            idx_next = 4'd0;
            if (kind == tccw_pkg::KIND_CHAR && char_code == tccw_pkg::CODE_NEWLINE)
            begin
                if (skip_reg)
                begin
                    skip_next = 1'b0;
                end
                else
                begin
                    col_next = '0;
                    row_next = row_inc;
                end
            end
            else if (kind == tccw_pkg::KIND_MOVE && pos_ok)
            begin
                col_next = pos_x[CW-1:0];
                row_next = pos_y[RW-1:0];
            end
        end
        else if (cmd.step)
        begin
            if (!last_digit)
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
        else if (cmd.emit)
        begin
            if (idx_reg != 4'd0)
            begin
                idx_next = idx_reg - 4'd1;
            end
            if (col_reg == COL_MAX)
            begin
                col_next  = '0;
                row_next  = row_inc;
                skip_next = 1'b1;
            end
            else
            begin
                col_next  = col_reg + 1'b1;
                skip_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            skip_reg <= 1'b0;
            idx_reg  <= 4'd0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            skip_reg <= skip_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= kind;
            code_reg <= char_code;
            num_reg  <= number;
        end
        else if (cmd.step)
        begin
            num_reg <= (kind_reg == tccw_pkg::KIND_HEX) ? (num_reg >> 4) : quot;
        end
        if (cmd.dec_mul || cmd.step)
        begin
            prod_reg <= mul_in * tccw_pkg::RECIP_TEN;
        end
        if (cmd.step)
        begin
            digit_reg[idx_reg] <= new_digit;
        end
        if (cmd.emit)
        begin
            glyph_reg <= glyph;
            cellc_reg <= col_w[3:0];
            cellr_reg <= row_w[2:0];
            last_reg  <= (idx_reg == 4'd0);
        end
    end

    assign glyph_index = glyph_reg;
    assign cell_column = cellc_reg;
    assign cell_row    = cellr_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ----- src/tccw_ctrl.sv -----
// Controller: sequences accept, digit extraction and glyph emission.
`timescale 1ns / 1ps
`default_nettype none

module tccw_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [1:0]            kind,
    input  wire logic [7:0]            char_code,
    output logic                       in_ready,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output tccw_pkg::dp_cmd_t          cmd,
    input  wire tccw_pkg::dp_status_t  status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HEX  = 3'd1;
    localparam logic [2:0] ST_DMUL = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    case (kind)
                        tccw_pkg::KIND_CHAR:
                        begin
                            if (char_code != tccw_pkg::CODE_NEWLINE)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        tccw_pkg::KIND_HEX: state_next = ST_HEX;
                        tccw_pkg::KIND_DEC: state_next = ST_DMUL;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HEX, ST_DEC:
            begin
                cmd.step = 1'b1;
                if (status.last_digit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DMUL:
            begin
                cmd.dec_mul = 1'b1;
                state_next  = ST_DEC;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && !out_valid_reg |=> out_valid_reg)
        else $error("emit state did not load the output word");

    a_hex_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == tccw_pkg::KIND_HEX |=> state_reg == ST_HEX)
        else $error("hex item did not start digit extraction");

    a_dmul_dec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DMUL |=> state_reg == ST_DEC)
        else $error("decimal multiply not followed by digit steps");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && status.idx_zero |=> state_reg == ST_IDLE && out_valid_reg)
        else $error("final glyph did not return controller to idle");

endmodule

`default_nettype wire

// ----- src/text_console_cursor_writer_core.sv -----
// Top level of the text console cursor writer.
// Flow: a character goes to the emit state, which loads its glyph word into the output
//   register; a hex number first extracts its digits, a decimal one first multiplies by
//   the reciprocal of ten; digits come one per cycle, glyph words one per cycle while the
//   output is ready. A new item is taken only in idle, once the previous one is done.
// Reset: cursor at column 0 row 0, newline skip cleared, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_writer_core #(
    parameter int COLUMNS         = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS            = tccw_pkg::ROWS_DEF,
    parameter int FIRST_PRINTABLE = tccw_pkg::FIRST_PRINTABLE_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tccw_in_if.sink     in_ch,
    tccw_out_if.source  out_ch
);

    tccw_pkg::dp_cmd_t    cmd;
    tccw_pkg::dp_status_t status;
    logic                 in_ready;
    logic                 out_valid;
    logic [6:0]           glyph_index;
    logic [3:0]           cell_column;
    logic [2:0]           cell_row;
    logic                 last;

    tccw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .kind      (in_ch.kind),
        .char_code (in_ch.char_code),
        .in_ready  (in_ready),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .cmd       (cmd),
        .status    (status)
    );

    tccw_datapath #(
        .COLUMNS         (COLUMNS),
        .ROWS            (ROWS),
        .FIRST_PRINTABLE (FIRST_PRINTABLE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (in_ch.kind),
        .char_code   (in_ch.char_code),
        .number      (in_ch.number),
        .pos_x       (in_ch.pos_x),
        .pos_y       (in_ch.pos_y),
        .glyph_index (glyph_index),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .last        (last)
    );

    assign in_ch.ready        = in_ready;
    assign out_ch.valid       = out_valid;
    assign out_ch.glyph_index = glyph_index;
    assign out_ch.cell_column = cell_column;
    assign out_ch.cell_row    = cell_row;
    assign out_ch.last        = last;

endmodule

`default_nettype wire

// ----- test/tb_text_console_cursor_writer_core.sv -----
// Self-checking testbench of the text console cursor writer core.
`timescale 1ns / 1ps

module tb_text_console_cursor_writer_core;

    localparam logic [1:0]  KIND_CHAR           = tccw_pkg::KIND_CHAR;
    localparam logic [1:0]  KIND_HEX            = tccw_pkg::KIND_HEX;
    localparam logic [1:0]  KIND_DEC            = tccw_pkg::KIND_DEC;
    localparam logic [1:0]  KIND_MOVE           = tccw_pkg::KIND_MOVE;
    localparam logic [7:0]  CODE_NEWLINE        = tccw_pkg::CODE_NEWLINE;
    localparam logic [7:0]  CODE_ZERO           = tccw_pkg::CODE_ZERO;
    localparam logic [7:0]  CODE_TOP            = tccw_pkg::CODE_TOP;
    localparam int          FIRST_PRINTABLE_DEF = tccw_pkg::FIRST_PRINTABLE_DEF;
    localparam int          COLUMNS_DEF         = tccw_pkg::COLUMNS_DEF;
    localparam int          ROWS_DEF            = tccw_pkg::ROWS_DEF;
    localparam int          DIGIT_DEPTH         = tccw_pkg::DIGIT_DEPTH;
    localparam logic [3:0]  HEX_LAST_IDX        = tccw_pkg::HEX_LAST_IDX;
    localparam logic [3:0]  DEC_LAST_IDX        = tccw_pkg::DEC_LAST_IDX;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          HOLD_AFTER     = 150;
    localparam int          TAIL_CYCLES    = 30;
    localparam int          RANDOM_ITEMS   = 445;
    localparam int          DRAIN_AT       = 250;
    localparam int          DIR_ROWS       = 25;
    localparam logic [7:0]  CODE_UPPER_A   = 8'd65;

    typedef struct packed {
        logic [6:0] glyph_index;
        logic [3:0] cell_column;
        logic [2:0] cell_row;
        logic       last;
    } glyph_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [31:0] number;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic        typed;
        glyph_word_t typed_word;
    } console_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    tccw_in_if  in_ch ();
    tccw_out_if out_ch ();

    text_console_cursor_writer_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #1 clk = ~clk;

    console_cmd_t offered_q [$];
    glyph_word_t  glyph_q [$];
    glyph_word_t  fresh_q [$];
    console_cmd_t dir_tab [DIR_ROWS];

    int cursor_col   = 0;
    int cursor_row   = 0;
    bit wrap_pending = 1'b0;

    int mismatches   = 0;
    int words_seen   = 0;
    int quiet_cycles = 0;
    int burst_left;
    bit hold_done    = 1'b0;

    function automatic console_cmd_t stim_row(input logic [1:0] kind, input logic [7:0] code,
                                              input logic [31:0] number, input logic [7:0] px,
                                              input logic [7:0] py, input logic typed,
                                              input logic [6:0] glyph, input logic [3:0] col,
                                              input logic [2:0] row);
        console_cmd_t c;
        c.kind       = kind;
        c.char_code  = code;
        c.number     = number;
        c.pos_x      = px;
        c.pos_y      = py;
        c.typed      = typed;
        c.typed_word = '{glyph_index: glyph, cell_column: col, cell_row: row, last: 1'b1};
        return c;
    endfunction

    function automatic console_cmd_t random_cmd(input logic [1:0] kind);
        console_cmd_t c;
        c.kind      = kind;
        c.char_code = 8'($urandom_range(0, 255));
        c.pos_x     = 8'($urandom_range(0, 255));
        c.pos_y     = 8'($urandom_range(0, 255));
        c.typed     = 1'b0;
        c.typed_word = '0;
        case ($urandom_range(0, 7))
            0: c.char_code = CODE_NEWLINE;
            1: c.char_code = 8'($urandom_range(0, 255));
            default: c.char_code = 8'($urandom_range(FIRST_PRINTABLE_DEF, CODE_TOP));
        endcase
        case ($urandom_range(0, 5))
            0: c.number = 32'd0;
            1: c.number = 32'hFFFF_FFFF;
            2: c.number = 32'($urandom_range(0, 15));
            default: c.number = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 3) != 0)
        begin
            c.pos_x = 8'($urandom_range(0, COLUMNS_DEF - 1));
            c.pos_y = 8'($urandom_range(0, ROWS_DEF - 1));
        end
        return c;
    endfunction

    function automatic logic [1:0] random_kind();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return KIND_CHAR;
        else if (pick < 63)
            return KIND_HEX;
        else if (pick < 81)
            return KIND_DEC;
        return KIND_MOVE;
    endfunction

    task automatic step_row();
        cursor_row = (cursor_row + 1 >= ROWS_DEF) ? 0 : cursor_row + 1;
    endtask

    task automatic place_glyph(input logic [7:0] code, input logic is_last);
        glyph_word_t w;
        if (code >= FIRST_PRINTABLE_DEF && code <= CODE_TOP)
            w.glyph_index = 7'(code - FIRST_PRINTABLE_DEF);
        else
            w.glyph_index = 7'd0;
        w.cell_column = 4'(cursor_col);
        w.cell_row    = 3'(cursor_row);
        w.last        = is_last;
        fresh_q.push_back(w);
        cursor_col++;
        if (cursor_col >= COLUMNS_DEF)
        begin
            cursor_col   = 0;
            step_row();
            wrap_pending = 1'b1;
        end
        else
        begin
            wrap_pending = 1'b0;
        end
    endtask

    task automatic render_cmd(input console_cmd_t c);
        logic [3:0]  digits [DIGIT_DEPTH];
        logic [31:0] val;
        logic [7:0]  ch;
        int          n;
        fresh_q.delete();
        val = c.number;
        n   = 0;
        case (c.kind)
            KIND_CHAR:
            begin
                if (c.char_code != CODE_NEWLINE)
                    place_glyph(c.char_code, 1'b1);
                else if (wrap_pending)
                    wrap_pending = 1'b0;
                else
                begin
                    cursor_col = 0;
                    step_row();
                end
            end
            KIND_MOVE:
            begin
                if (c.pos_x < COLUMNS_DEF && c.pos_y < ROWS_DEF)
                begin
                    cursor_col = c.pos_x;
                    cursor_row = c.pos_y;
                end
            end
            default:
            begin
                if (c.kind == KIND_HEX)
                begin
                    do
                    begin
                        digits[n] = val[3:0];
                        val       = val >> 4;
                        n++;
                    end while (val != 0 && n <= HEX_LAST_IDX);
                end
                else
                begin
                    do
                    begin
                        digits[n] = 4'(val % 10);
                        val       = val / 10;
                        n++;
                    end while (val != 0 && n <= DEC_LAST_IDX);
                end
                for (int i = 0; i < n; i++)
                begin
                    if (digits[n - 1 - i] < 10)
                        ch = CODE_ZERO + 8'(digits[n - 1 - i]);
                    else
                        ch = CODE_UPPER_A + 8'(digits[n - 1 - i]) - 8'd10;
                    place_glyph(ch, i == n - 1);
                end
            end
        endcase
        if (c.typed)
            glyph_q.push_back(c.typed_word);
        else
            foreach (fresh_q[i])
                glyph_q.push_back(fresh_q[i]);
    endtask

    task automatic report_word(input string what, input glyph_word_t want,
                               input glyph_word_t got);
        if (mismatches < 10)
            $display("%0t %s: expected g%0d c%0d r%0d l%0d, got g%0d c%0d r%0d l%0d",
                     $time, what, want.glyph_index, want.cell_column, want.cell_row, want.last,
                     got.glyph_index, got.cell_column, got.cell_row, got.last);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : glyph_monitor
        glyph_word_t got;
        glyph_word_t want;
        logic        moved;
        moved = 1'b0;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            render_cmd(offered_q.pop_front());
            moved = 1'b1;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            moved = 1'b1;
            words_seen++;
            got = '{glyph_index: out_ch.glyph_index, cell_column: out_ch.cell_column,
                    cell_row: out_ch.cell_row, last: out_ch.last};
            if (glyph_q.size() == 0)
                report_word("unexpected glyph word", '0, got);
            else
            begin
                want = glyph_q.pop_front();
                if (got.glyph_index !== want.glyph_index || got.cell_column !== want.cell_column
                    || got.cell_row !== want.cell_row || got.last !== want.last)
                    report_word("glyph word mismatch", want, got);
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin : out_throttle
        int mode;
        int span;
        int tick;
        tick         = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(negedge clk);
                if (!hold_done && words_seen >= HOLD_AFTER)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
                tick++;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_cmd(input console_cmd_t c);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        offered_q.push_back(c);
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= c.kind;
        in_ch.char_code <= c.char_code;
        in_ch.number    <= c.number;
        in_ch.pos_x     <= c.pos_x;
        in_ch.pos_y     <= c.pos_y;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_glyphs();
        while (glyph_q.size() != 0 || offered_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        console_cmd_t c;
        int           sent;
        int           pick;
        bit           drained;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_CHAR;
        in_ch.char_code = '0;
        in_ch.number    = '0;
        in_ch.pos_x     = '0;
        in_ch.pos_y     = '0;
        burst_left      = 0;
        sent            = 0;
        drained         = 1'b0;

        dir_tab[0]  = stim_row(KIND_CHAR, 8'd65,  '0, '0, '0, 1'b1, 7'd33, 4'd0, 3'd0);
        dir_tab[1]  = stim_row(KIND_CHAR, 8'd0,   '0, '0, '0, 1'b1, 7'd0,  4'd1, 3'd0);
        dir_tab[2]  = stim_row(KIND_CHAR, 8'd255, '0, '0, '0, 1'b1, 7'd0,  4'd2, 3'd0);
        dir_tab[3]  = stim_row(KIND_CHAR, 8'd127, '0, '0, '0, 1'b1, 7'd95, 4'd3, 3'd0);
        dir_tab[4]  = stim_row(KIND_CHAR, 8'd32,  '0, '0, '0, 1'b1, 7'd0,  4'd4, 3'd0);
        dir_tab[5]  = stim_row(KIND_CHAR, 8'd31,  '0, '0, '0, 1'b1, 7'd0,  4'd5, 3'd0);
        dir_tab[6]  = stim_row(KIND_HEX,  '0, 32'd0, '0, '0, 1'b1, 7'd16, 4'd6, 3'd0);
        dir_tab[7]  = stim_row(KIND_DEC,  '0, 32'd0, '0, '0, 1'b1, 7'd16, 4'd7, 3'd0);
        dir_tab[8]  = stim_row(KIND_CHAR, 8'd126, '0, '0, '0, 1'b0, '0, '0, '0);
        dir_tab[9]  = stim_row(KIND_HEX,  '0, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0, '0);
        dir_tab[10] = stim_row(KIND_DEC,  '0, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0, '0);
        dir_tab[11] = stim_row(KIND_CHAR, CODE_NEWLINE, '0, '0, '0, 1'b0, '0, '0, '0);
        dir_tab[12] = stim_row(KIND_MOVE, '0, '0, 8'd15, 8'd7, 1'b0, '0, '0, '0);
        dir_tab[13] = stim_row(KIND_CHAR, 8'd122, '0, '0, '0, 1'b1, 7'd90, 4'd15, 3'd7);
        dir_tab[14] = stim_row(KIND_CHAR, CODE_NEWLINE, '0, '0, '0, 1'b0, '0, '0, '0);
        dir_tab[15] = stim_row(KIND_CHAR, 8'd66,  '0, '0, '0, 1'b1, 7'd34, 4'd0, 3'd0);
        dir_tab[16] = stim_row(KIND_MOVE, '0, '0, 8'd16,  8'd0,   1'b0, '0, '0, '0);
        dir_tab[17] = stim_row(KIND_MOVE, '0, '0, 8'd0,   8'd8,   1'b0, '0, '0, '0);
        dir_tab[18] = stim_row(KIND_MOVE, '0, '0, 8'd255, 8'd255, 1'b0, '0, '0, '0);
        dir_tab[19] = stim_row(KIND_CHAR, 8'd67,  '0, '0, '0, 1'b1, 7'd35, 4'd1, 3'd0);
        dir_tab[20] = stim_row(KIND_CHAR, CODE_NEWLINE, '0, '0, '0, 1'b0, '0, '0, '0);
        dir_tab[21] = stim_row(KIND_CHAR, CODE_NEWLINE, '0, '0, '0, 1'b0, '0, '0, '0);
        dir_tab[22] = stim_row(KIND_MOVE, '0, '0, 8'd0, 8'd7, 1'b0, '0, '0, '0);
        dir_tab[23] = stim_row(KIND_CHAR, CODE_NEWLINE, '0, '0, '0, 1'b0, '0, '0, '0);
        dir_tab[24] = stim_row(KIND_CHAR, CODE_ZERO, '0, '0, '0, 1'b1, 7'd16, 4'd0, 3'd0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_cmd(dir_tab[i]);

        while (sent < RANDOM_ITEMS)
        begin
            if (!drained && sent >= DRAIN_AT)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
                drain_glyphs();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_cmd(random_cmd(random_kind()));
                sent++;
            end
            else if (pick < 85)
            begin
                c       = random_cmd(KIND_MOVE);
                c.pos_x = 8'(COLUMNS_DEF - 1);
                c.pos_y = 8'($urandom_range(0, ROWS_DEF - 1));
                send_cmd(c);
                c = random_cmd(KIND_CHAR);
                c.char_code = 8'($urandom_range(FIRST_PRINTABLE_DEF, CODE_TOP));
                send_cmd(c);
                c.char_code = CODE_NEWLINE;
                send_cmd(c);
                c.char_code = 8'($urandom_range(0, 255));
                send_cmd(c);
                sent += 4;
            end
            else
            begin
                c       = random_cmd(KIND_MOVE);
                c.pos_x = 8'($urandom_range(8, COLUMNS_DEF - 1));
                c.pos_y = 8'($urandom_range(0, ROWS_DEF - 1));
                send_cmd(c);
                send_cmd(random_cmd($urandom_range(0, 1) ? KIND_HEX : KIND_DEC));
                c = random_cmd(KIND_CHAR);
                c.char_code = CODE_NEWLINE;
                send_cmd(c);
                sent += 3;
            end
        end

        in_ch.valid <= 1'b0;
        drain_glyphs();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
